// ===== src/gct_pkg.sv =====
// Shared types and constants for the greedy centroid tracker.
`default_nettype none

package gct_pkg;

  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_MISS_LIMIT    = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_GATE_DISTANCE = 8'd1;

  localparam logic [7:0]  MissLimitReset = 8'd30;
  localparam logic [15:0] GateReset      = 16'd800;
  localparam logic [31:0] Gate2Reset     = 32'd640000;

  localparam logic [1:0] REQ_DETECT = 2'd0;
  localparam logic [1:0] REQ_FRAME  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] ST_MATCH = 2'd0;
  localparam logic [1:0] ST_NEW   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        frame_last;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  det_index;
    logic [15:0] track_id;
    logic [1:0]  status;
    logic        run_last;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_DET      = 2'd0,
    CMD_DET_LAST = 2'd1,
    CMD_FRAME    = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [15:0] x;
    logic [15:0] y;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] id;
  } asg_t;

endpackage

`default_nettype wire

// ===== src/gct_fifo.sv =====
// Small first-in first-out queue used between the tracker stages.
`default_nettype none

module gct_fifo #(
  parameter type T     = logic [0:0],
  parameter int  Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire T     data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output T          data_o,
  output logic      empty_o
);

  localparam int AW = $clog2(Depth);

  T               mem_q [Depth];
  logic [AW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]    cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + AW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + AW'(1) : rd_q;
    cnt_d = cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/gct_front.sv =====
// Input side: accepts items, turns them into commands and queues them.
`default_nettype none

module gct_front import gct_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire in_item_t item_i,
  output logic          full_o,
  output cmd_t          cmd_o,
  output logic          cmd_valid_o,
  input  wire logic     cmd_pop_i
);

  cmd_t cmd;
  logic known;
  logic cmd_empty;

  always_comb begin
    cmd.x  = item_i.pos_x;
    cmd.y  = item_i.pos_y;
    known  = 1'b1;
    unique case (item_i.req_type)
      REQ_DETECT: cmd.op = item_i.frame_last ? CMD_DET_LAST : CMD_DET;
      REQ_FRAME:  cmd.op = CMD_FRAME;
      REQ_CLEAR:  cmd.op = CMD_CLEAR;
      default: begin
        // Unused request codes are accepted and dropped here.
        cmd.op = CMD_FRAME;
        known  = 1'b0;
      end
    endcase
  end

  gct_fifo #(.T(cmd_t), .Depth(2)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && known),
    .data_i  (cmd),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

`default_nettype wire

// ===== src/gct_back.sv =====
// Back end: frame buffer, track table and the matching sequencer.
`default_nettype none

module gct_back import gct_pkg::*; #(
  parameter int MAX_TRACKS     = 32,
  parameter int MAX_DETECTIONS = 32,
  parameter int COORD_BITS     = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  input  wire logic                cmd_valid_i,
  output logic                     cmd_pop_o,
  input  wire logic                cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output out_item_t                res_o,
  output logic                     res_push_o,
  input  wire logic                res_full_i
);

  localparam int TW  = $clog2(MAX_TRACKS);
  localparam int TCW = $clog2(MAX_TRACKS + 1);
  localparam int DW  = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam int DCW = $clog2(MAX_DETECTIONS + 1);
  localparam int CB  = COORD_BITS;
  localparam int SQW = 2 * CB;
  localparam int BW  = (SQW + 1 > 32) ? SQW + 1 : 32;

  typedef struct packed {
    logic [15:0]   id;
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [7:0]    missed;
  } trk_word_t;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
  } det_word_t;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_M_RD     = 13'b0000000000010,
    S_M_SLOT   = 13'b0000000000100,
    S_M_TRK    = 13'b0000000001000,
    S_M_SCAN   = 13'b0000000010000,
    S_M_COMMIT = 13'b0000000100000,
    S_A_RD     = 13'b0000001000000,
    S_A_SLOT   = 13'b0000010000000,
    S_A_TRK    = 13'b0000100000000,
    S_N_CHK    = 13'b0001000000000,
    S_N_WR     = 13'b0010000000000,
    S_O_RD     = 13'b0100000000000,
    S_O_PUSH   = 13'b1000000000000
  } state_e;

  // Memories with registered read data.
  det_word_t det_mem [MAX_DETECTIONS];
  trk_word_t trk_mem [MAX_TRACKS];
  logic [TW-1:0] ord_mem [MAX_TRACKS];
  asg_t      asg_mem [MAX_DETECTIONS];

  det_word_t     det_rd_q;
  trk_word_t     trk_rd_q;
  logic [TW-1:0] ord_rd_q;
  asg_t          asg_rd_q;

  logic          det_we, trk_we, ord_we, asg_we;
  det_word_t     det_wd;
  trk_word_t     trk_wd;
  logic [TW-1:0] trk_wa, ord_wa, ord_wd;
  logic [DW-1:0] asg_wa;
  asg_t          asg_wd;

  state_e              state_q, state_d;
  logic [TCW-1:0]      r_q, r_d, w_q, w_d, len_q, len_d, fs_q, fs_d;
  logic [DCW-1:0]      i_q, i_d, det_cnt_q, det_cnt_d;
  logic [15:0]         id_q, id_d;
  logic [MAX_TRACKS-1:0]     valid_q, valid_d, hit_q, hit_d;
  logic [MAX_DETECTIONS-1:0] claimed_q, claimed_d;
  logic                p1_v_q, p2_v_q, p3_v_q;
  logic                found_q, found_d;
  logic [7:0]          miss_limit_q;
  logic [15:0]         gate_q;
  logic [31:0]         gate2_q;

  // Payload registers.
  logic [TW-1:0]  s_q;
  trk_word_t      trk_q;
  logic [BW-1:0]  best_q;
  logic [DW-1:0]  bi_q;
  logic [CB-1:0]  bx_q, by_q;
  logic [DW-1:0]  p1_idx_q, p2_idx_q, p3_idx_q;
  logic           p1_clm_q, p2_clm_q, p3_clm_q;
  logic [CB-1:0]  dx_q, dy_q, p2_x_q, p2_y_q, p3_x_q, p3_y_q;
  logic [SQW-1:0] sqx_q, sqy_q;

  logic           issue, better, start;
  logic [BW-1:0]  sum;
  logic [CB-1:0]  dx, dy;
  logic [8:0]     aged;

  assign issue  = (state_q == S_M_SCAN) && (i_q != det_cnt_q);
  assign sum    = BW'(sqx_q) + BW'(sqy_q);
  assign better = p3_v_q && !p3_clm_q && (sum < best_q);
  assign dx     = (trk_q.x > det_rd_q.x) ? trk_q.x - det_rd_q.x : det_rd_q.x - trk_q.x;
  assign dy     = (trk_q.y > det_rd_q.y) ? trk_q.y - det_rd_q.y : det_rd_q.y - trk_q.y;
  assign aged   = {1'b0, trk_rd_q.missed} + 9'd1;

  always_comb begin
    state_d   = state_q;
    r_d       = r_q;
    w_d       = w_q;
    len_d     = len_q;
    fs_d      = fs_q;
    i_d       = i_q;
    det_cnt_d = det_cnt_q;
    id_d      = id_q;
    valid_d   = valid_q;
    hit_d     = hit_q;
    claimed_d = claimed_q;
    found_d   = found_q;
    cmd_pop_o = 1'b0;
    start     = 1'b0;
    det_we    = 1'b0;
    det_wd.x  = CB'(cmd_i.x);
    det_wd.y  = CB'(cmd_i.y);
    trk_we    = 1'b0;
    trk_wa    = s_q;
    trk_wd    = trk_q;
    ord_we    = 1'b0;
    ord_wa    = w_q[TW-1:0];
    ord_wd    = s_q;
    asg_we    = 1'b0;
    asg_wa    = bi_q;
    asg_wd    = '{status: ST_MATCH, id: trk_q.id};
    res_push_o = 1'b0;
    res_o.det_index = 5'(i_q);
    res_o.track_id  = asg_rd_q.id;
    res_o.status    = asg_rd_q.status;
    res_o.run_last  = ((i_q + DCW'(1)) == det_cnt_q);

    if (better) begin
      found_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            CMD_DET, CMD_DET_LAST: begin
              // Detections past the buffer depth are dropped.
              if (det_cnt_q < DCW'(MAX_DETECTIONS)) begin
                det_we    = 1'b1;
                det_cnt_d = det_cnt_q + DCW'(1);
              end
              start = (cmd_i.op == CMD_DET_LAST);
            end
            CMD_FRAME: start = 1'b1;
            CMD_CLEAR: begin
              valid_d   = '0;
              len_d     = '0;
              id_d      = '0;
              det_cnt_d = '0;
            end
            default: start = 1'b0;
          endcase
          if (start) begin
            claimed_d = '0;
            hit_d     = '0;
            r_d       = '0;
            state_d   = S_M_RD;
          end
        end
      end
      S_M_RD: begin
        if (r_q == len_q) begin
          r_d     = '0;
          w_d     = '0;
          state_d = S_A_RD;
        end else begin
          state_d = S_M_SLOT;
        end
      end
      S_M_SLOT: state_d = S_M_TRK;
      S_M_TRK: begin
        found_d = 1'b0;
        i_d     = '0;
        state_d = S_M_SCAN;
      end
      S_M_SCAN: begin
        if (issue) begin
          i_d = i_q + DCW'(1);
        end else if (!p1_v_q && !p2_v_q && !p3_v_q) begin
          state_d = S_M_COMMIT;
        end
      end
      S_M_COMMIT: begin
        if (found_q) begin
          claimed_d[bi_q] = 1'b1;
          hit_d[s_q]      = 1'b1;
          trk_we          = 1'b1;
          trk_wd.x        = bx_q;
          trk_wd.y        = by_q;
          asg_we          = 1'b1;
        end
        r_d     = r_q + TCW'(1);
        state_d = S_M_RD;
      end
      S_A_RD: begin
        if (r_q == len_q) begin
          i_d     = '0;
          fs_d    = '0;
          state_d = S_N_CHK;
        end else begin
          state_d = S_A_SLOT;
        end
      end
      S_A_SLOT: state_d = S_A_TRK;
      S_A_TRK: begin
        trk_wd = trk_rd_q;
        if (hit_q[s_q]) begin
          trk_we        = 1'b1;
          trk_wd.missed = 8'd0;
          ord_we        = 1'b1;
          w_d           = w_q + TCW'(1);
        end else if (aged > {1'b0, miss_limit_q}) begin
          valid_d[s_q] = 1'b0;
        end else begin
          trk_we        = 1'b1;
          trk_wd.missed = aged[7:0];
          ord_we        = 1'b1;
          w_d           = w_q + TCW'(1);
        end
        r_d     = r_q + TCW'(1);
        state_d = S_A_RD;
      end
      S_N_CHK: begin
        if (i_q == det_cnt_q) begin
          len_d   = w_q;
          i_d     = '0;
          state_d = S_O_RD;
        end else if (claimed_q[i_q[DW-1:0]]) begin
          i_d = i_q + DCW'(1);
        end else if (fs_q != TCW'(MAX_TRACKS) && valid_q[fs_q[TW-1:0]]) begin
          // Free slots are taken in rising order, so the scan never goes back.
          fs_d = fs_q + TCW'(1);
        end else begin
          state_d = S_N_WR;
        end
      end
      S_N_WR: begin
        asg_we = 1'b1;
        asg_wa = i_q[DW-1:0];
        if (fs_q == TCW'(MAX_TRACKS)) begin
          asg_wd = '{status: ST_FULL, id: 16'd0};
        end else begin
          trk_we  = 1'b1;
          trk_wa  = fs_q[TW-1:0];
          trk_wd  = '{id: id_q, x: det_rd_q.x, y: det_rd_q.y, missed: 8'd0};
          valid_d[fs_q[TW-1:0]] = 1'b1;
          ord_we  = 1'b1;
          ord_wd  = fs_q[TW-1:0];
          w_d     = w_q + TCW'(1);
          asg_wd  = '{status: ST_NEW, id: id_q};
          id_d    = id_q + 16'd1;
          fs_d    = fs_q + TCW'(1);
        end
        i_d     = i_q + DCW'(1);
        state_d = S_N_CHK;
      end
      S_O_RD: begin
        if (i_q == det_cnt_q) begin
          det_cnt_d = '0;
          state_d   = S_IDLE;
        end else begin
          state_d = S_O_PUSH;
        end
      end
      S_O_PUSH: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          i_d        = i_q + DCW'(1);
          state_d    = S_O_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      r_q          <= '0;
      w_q          <= '0;
      len_q        <= '0;
      fs_q         <= '0;
      i_q          <= '0;
      det_cnt_q    <= '0;
      id_q         <= '0;
      valid_q      <= '0;
      hit_q        <= '0;
      claimed_q    <= '0;
      found_q      <= 1'b0;
      p1_v_q       <= 1'b0;
      p2_v_q       <= 1'b0;
      p3_v_q       <= 1'b0;
      miss_limit_q <= MissLimitReset;
      gate_q       <= GateReset;
      gate2_q      <= Gate2Reset;
    end else begin
      state_q   <= state_d;
      r_q       <= r_d;
      w_q       <= w_d;
      len_q     <= len_d;
      fs_q      <= fs_d;
      i_q       <= i_d;
      det_cnt_q <= det_cnt_d;
      id_q      <= id_d;
      valid_q   <= valid_d;
      hit_q     <= hit_d;
      claimed_q <= claimed_d;
      found_q   <= found_d;
      p1_v_q    <= issue;
      p2_v_q    <= p1_v_q;
      p3_v_q    <= p2_v_q;
      gate2_q   <= 32'(gate_q) * 32'(gate_q);
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_MISS_LIMIT) begin
          miss_limit_q <= cfg_data_i[7:0];
        end else if (cfg_index_i == CFG_GATE_DISTANCE) begin
          gate_q <= cfg_data_i;
        end
      end
    end
  end

  // Distance pipeline: absolute differences, squares, then sum and compare.
  always_ff @(posedge clk_i) begin
    if (state_q == S_M_SLOT || state_q == S_A_SLOT) begin
      s_q <= ord_rd_q;
    end
    if (state_q == S_M_TRK) begin
      trk_q  <= trk_rd_q;
      best_q <= BW'(gate2_q);
    end
    p1_idx_q <= i_q[DW-1:0];
    p1_clm_q <= claimed_q[i_q[DW-1:0]];
    dx_q     <= dx;
    dy_q     <= dy;
    p2_x_q   <= det_rd_q.x;
    p2_y_q   <= det_rd_q.y;
    p2_idx_q <= p1_idx_q;
    p2_clm_q <= p1_clm_q;
    sqx_q    <= SQW'(dx_q) * SQW'(dx_q);
    sqy_q    <= SQW'(dy_q) * SQW'(dy_q);
    p3_x_q   <= p2_x_q;
    p3_y_q   <= p2_y_q;
    p3_idx_q <= p2_idx_q;
    p3_clm_q <= p2_clm_q;
    if (better) begin
      best_q <= sum;
      bi_q   <= p3_idx_q;
      bx_q   <= p3_x_q;
      by_q   <= p3_y_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (det_we) begin
      det_mem[det_cnt_q[DW-1:0]] <= det_wd;
    end
    det_rd_q <= det_mem[i_q[DW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (trk_we) begin
      trk_mem[trk_wa] <= trk_wd;
    end
    trk_rd_q <= trk_mem[ord_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    ord_rd_q <= ord_mem[r_q[TW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (asg_we) begin
      asg_mem[asg_wa] <= asg_wd;
    end
    asg_rd_q <= asg_mem[i_q[DW-1:0]];
  end

endmodule

`default_nettype wire

// ===== src/greedy_centroid_tracker.sv =====
// Greedy nearest-neighbor centroid tracker, top level.
//
// Items enter through push_i/full_o and results leave through empty_o/pop_i,
// both queue style. Configuration writes use cfg_valid_i/cfg_ready_o; ready
// is always high and index 0 sets the miss limit, index 1 the gate distance.
// A detection item is written into the frame buffer when the idle sequencer
// takes it from the command queue. An item that closes a frame starts
// matching: each live track takes a pass over the buffered detections through
// the squared distance pipeline, one two-multiplier pipeline shared by all
// tracks. Then every track is aged, each unclaimed detection gets a new track
// in a free slot while any is left, and one result goes out per detection.
// A two-entry command queue lets new items be accepted while a frame runs.
// Results wait in a four-entry queue; when the receiver stalls and it fills,
// the sequencer holds until pop_i drains it. Reset empties both queues, drops
// all tracks, zeroes the id counter and restores the register defaults.
`default_nettype none

module greedy_centroid_tracker import gct_pkg::*; #(
  parameter int MAX_TRACKS     = 32,
  parameter int MAX_DETECTIONS = 32,
  parameter int COORD_BITS     = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire in_item_t            item_i,
  output logic                     full_o,
  output out_item_t                result_o,
  output logic                     empty_o,
  input  wire logic                pop_i,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t      cmd;
  logic      cmd_valid, cmd_pop;
  out_item_t res;
  logic      res_push, res_full;

  assign cfg_ready_o = 1'b1;

  gct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .item_i      (item_i),
    .full_o      (full_o),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  gct_back #(
    .MAX_TRACKS     (MAX_TRACKS),
    .MAX_DETECTIONS (MAX_DETECTIONS),
    .COORD_BITS     (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  gct_fifo #(.T(out_item_t), .Depth(4)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (result_o),
    .empty_o (empty_o)
  );

endmodule

`default_nettype wire

// ===== src/gct_checker.sv =====
// Port-level checks for the tracker and their binding to the top level.
`default_nettype none

module gct_checker import gct_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      empty_o,
  input wire logic      pop_i,
  input wire out_item_t result_o
);

  // The result queue is empty in the cycle after reset is seen.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty_o)
    else $error("result queue not empty in reset");

  // Within a frame, results come in rising detection order.
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o && !result_o.run_last) |=>
      (empty_o || result_o.det_index == $past(result_o.det_index) + 5'd1))
    else $error("detection index skipped");

  // A new frame's results start at detection zero.
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o && result_o.run_last) |=>
      (empty_o || result_o.det_index == 5'd0))
    else $error("frame does not start at index zero");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (result_o.status == ST_MATCH || result_o.status == ST_NEW ||
                  result_o.status == ST_FULL))
    else $error("bad status code");

  // A detection that found no slot carries id zero.
  a_full_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && result_o.status == ST_FULL) |-> result_o.track_id == 16'd0)
    else $error("table-full result with nonzero id");

endmodule

bind greedy_centroid_tracker gct_checker u_checker (.*);

`default_nettype wire

// ===== tb/greedy_centroid_tracker_tb.sv =====
// Self-checking testbench for the greedy centroid tracker: random frames, predictor, scoreboard.
`timescale 1ns / 1ps

module greedy_centroid_tracker_tb;
  import gct_pkg::*;

  localparam int NTRK       = 32;
  localparam int NDET       = 32;
  localparam int SETTLE_CYC = 2000;
  localparam int STALL_MAX  = 50000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push_i = 1'b0;
  in_item_t            item_i = '0;
  logic                full_o;
  out_item_t           result_o;
  logic                empty_o;
  logic                pop_i = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  greedy_centroid_tracker dut (
    .clk_i, .rst_ni, .push_i, .item_i, .full_o, .result_o, .empty_o, .pop_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Predicted tracker state.
  logic [7:0]  miss_lim = MissLimitReset;
  logic [15:0] gate     = GateReset;
  logic [15:0] frm_x[NDET];
  logic [15:0] frm_y[NDET];
  int          frm_n = 0;
  bit          trk_live[NTRK];
  logic [15:0] trk_tag[NTRK];
  logic [15:0] trk_px[NTRK];
  logic [15:0] trk_py[NTRK];
  int          trk_miss[NTRK];
  int          trk_rank[NTRK];
  logic [15:0] id_next = '0;

  in_item_t    queued_items[$];
  out_item_t   expected_assignments[$];
  int          errors = 0;
  int          cycle_cnt = 0;
  int          stall_cnt = 0;
  bit          steady;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void forget_tracks();
    for (int s = 0; s < NTRK; s++) trk_live[s] = 1'b0;
    frm_n   = 0;
    id_next = '0;
  endfunction

  // Match, age, prune, then create tracks; one expected assignment per detection.
  function automatic void associate_frame();
    bit          hit[NTRK];
    bit          taken[NDET];
    asg_t        asg[NDET];
    int          ntrk;
    int          s;
    int          r0;
    int          bi;
    logic [63:0] gate2;
    logic [63:0] best;
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] d2;
    out_item_t   res;
    ntrk  = 0;
    gate2 = 64'(gate) * 64'(gate);
    for (int t = 0; t < NTRK; t++) begin
      hit[t] = 1'b0;
      if (trk_live[t]) ntrk++;
    end
    for (int i = 0; i < NDET; i++) begin
      taken[i] = 1'b0;
      asg[i]   = '0;
    end
    for (int r = 0; r < ntrk; r++) begin
      for (s = 0; s < NTRK; s++)
        if (trk_live[s] && trk_rank[s] == r) break;
      if (s < NTRK) begin
        best = gate2;
        bi   = -1;
        for (int i = 0; i < frm_n; i++) begin
          if (!taken[i]) begin
            dx = (trk_px[s] > frm_x[i]) ? 64'(trk_px[s] - frm_x[i]) : 64'(frm_x[i] - trk_px[s]);
            dy = (trk_py[s] > frm_y[i]) ? 64'(trk_py[s] - frm_y[i]) : 64'(frm_y[i] - trk_py[s]);
            d2 = dx * dx + dy * dy;
            if (d2 < best) begin
              best = d2;
              bi   = i;
            end
          end
        end
        if (bi >= 0) begin
          taken[bi]  = 1'b1;
          trk_px[s]  = frm_x[bi];
          trk_py[s]  = frm_y[bi];
          hit[s]     = 1'b1;
          asg[bi].id = trk_tag[s];
          asg[bi].status = ST_MATCH;
        end
      end
    end
    for (int t = 0; t < NTRK; t++) begin
      if (trk_live[t]) begin
        if (hit[t]) begin
          trk_miss[t] = 0;
        end else if (trk_miss[t] + 1 > int'(miss_lim)) begin
          // Removing a track closes the gap in the age ranking.
          trk_live[t] = 1'b0;
          r0 = trk_rank[t];
          for (int u = 0; u < NTRK; u++)
            if (trk_live[u] && trk_rank[u] > r0) trk_rank[u]--;
        end else begin
          trk_miss[t]++;
        end
      end
    end
    for (int i = 0; i < frm_n; i++) begin
      if (!taken[i]) begin
        for (s = 0; s < NTRK; s++)
          if (!trk_live[s]) break;
        if (s < NTRK) begin
          ntrk = 0;
          for (int t = 0; t < NTRK; t++)
            if (trk_live[t]) ntrk++;
          trk_rank[s] = ntrk;
          trk_live[s] = 1'b1;
          trk_tag[s]  = id_next;
          trk_px[s]   = frm_x[i];
          trk_py[s]   = frm_y[i];
          trk_miss[s] = 0;
          asg[i].id     = id_next;
          asg[i].status = ST_NEW;
          id_next++;
        end else begin
          asg[i].id     = '0;
          asg[i].status = ST_FULL;
        end
      end
    end
    for (int i = 0; i < frm_n; i++) begin
      res.det_index = 5'(i);
      res.track_id  = asg[i].id;
      res.status    = asg[i].status;
      res.run_last  = (i + 1 == frm_n);
      expected_assignments.push_back(res);
    end
    frm_n = 0;
  endfunction

  function automatic void absorb_item(input in_item_t it);
    case (it.req_type)
      REQ_DETECT: begin
        if (frm_n < NDET) begin
          frm_x[frm_n] = it.pos_x;
          frm_y[frm_n] = it.pos_y;
          frm_n++;
        end
        if (it.frame_last) associate_frame();
      end
      REQ_FRAME: associate_frame();
      REQ_CLEAR: forget_tracks();
      default: ;
    endcase
  endfunction

  assign steady = (cycle_cnt > 4000 && cycle_cnt < 9000);

  // Driver.
  always @(posedge clk_i) begin
    if (push_i && !full_o) absorb_item(item_i);
    if (!push_i || !full_o) begin
      if (queued_items.size() > 0 && rst_ni && (steady || $urandom_range(99) >= 19)) begin
        push_i <= 1'b1;
        item_i <= queued_items.pop_front();
      end else begin
        push_i <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    out_item_t want;
    if (pop_i && !empty_o) begin
      if (expected_assignments.size() == 0) begin
        report("result with nothing expected, det_index", result_o.det_index, -1);
      end else begin
        want = expected_assignments.pop_front();
        if (result_o.det_index !== want.det_index)
          report("det_index", result_o.det_index, want.det_index);
        if (result_o.track_id !== want.track_id)
          report("track_id", result_o.track_id, want.track_id);
        if (result_o.status !== want.status)
          report("status", result_o.status, want.status);
        if (result_o.run_last !== want.run_last)
          report("run_last", result_o.run_last, want.run_last);
      end
    end
    pop_i <= rst_ni && (steady || $urandom_range(99) >= 19);
  end

  // Watchdog on cycles in which nothing is accepted.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if ((push_i && !full_o) || (pop_i && !empty_o) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("watchdog expired");
      $display("tb: failure");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic add(input logic [1:0] req, input int x, input int y, input bit last);
    in_item_t it;
    it.req_type   = req;
    it.pos_x      = 16'(x);
    it.pos_y      = 16'(y);
    it.frame_last = last;
    queued_items.push_back(it);
  endtask

  // Hold the sender until the block is idle and every result has come.
  task automatic settle();
    while (queued_items.size() > 0 || push_i) @(posedge clk_i);
    while (expected_assignments.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 16'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_MISS_LIMIT) miss_lim = 8'(val);
    else gate = 16'(val);
    @(posedge clk_i);
  endtask

  // Objects drift slowly so most tracks find their detection again.
  int obj_x[8];
  int obj_y[8];

  task automatic random_traffic(input int n_items);
    int cnt;
    int sel;
    int n;
    cnt = 0;
    for (int k = 0; k < 8; k++) begin
      obj_x[k] = $urandom_range(65535);
      obj_y[k] = $urandom_range(65535);
    end
    while (cnt < n_items) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        n = ($urandom_range(99) < 6) ? $urandom_range(20, 35) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          if (i < 8 && $urandom_range(9) > 1) begin
            obj_x[i] = obj_x[i] + $urandom_range(600) - 300;
            obj_y[i] = obj_y[i] + $urandom_range(600) - 300;
            if (obj_x[i] < 0) obj_x[i] = 0;
            if (obj_x[i] > 65535) obj_x[i] = 65535;
            if (obj_y[i] < 0) obj_y[i] = 0;
            if (obj_y[i] > 65535) obj_y[i] = 65535;
            add(REQ_DETECT, obj_x[i], obj_y[i], i == n - 1);
          end else begin
            add(REQ_DETECT, $urandom_range(65535), $urandom_range(65535), i == n - 1);
          end
        end
        cnt += n;
      end else if (sel < 82) begin
        add(REQ_FRAME, $urandom_range(65535), $urandom_range(65535), $urandom_range(1));
        cnt++;
      end else if (sel < 85) begin
        add(REQ_CLEAR, $urandom_range(65535), $urandom_range(65535), $urandom_range(1));
        cnt++;
      end else if (sel < 89) begin
        add(REQ_UNUSED, $urandom_range(65535), $urandom_range(65535), $urandom_range(1));
      end else begin
        // A stray detection that joins whatever frame comes next.
        add(REQ_DETECT, $urandom_range(65535), $urandom_range(65535), 1'b0);
        cnt++;
      end
    end
  endtask

  initial begin
    for (int s = 0; s < NTRK; s++) trk_live[s] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add(REQ_DETECT, 0, 0, 1'b1);
    add(REQ_DETECT, 65535, 65535, 1'b0);
    add(REQ_DETECT, 65535, 0, 1'b1);
    add(REQ_FRAME, 0, 0, 1'b0);
    add(REQ_DETECT, 5, 5, 1'b0);
    add(REQ_FRAME, 65535, 65535, 1'b1);
    add(REQ_UNUSED, 65535, 65535, 1'b1);
    add(REQ_DETECT, 40, 40, 1'b1);
    add(REQ_DETECT, 0, 20, 1'b0);
    add(REQ_DETECT, 20, 0, 1'b1);
    add(REQ_CLEAR, 0, 0, 1'b0);
    add(REQ_DETECT, 0, 65535, 1'b1);
    add(REQ_FRAME, 0, 0, 1'b0);
    add(REQ_FRAME, 0, 0, 1'b0);
    settle();

    write_reg(CFG_MISS_LIMIT, 255);
    write_reg(CFG_GATE_DISTANCE, 65535);
    random_traffic(110);
    settle();

    write_reg(CFG_MISS_LIMIT, 0);
    write_reg(CFG_GATE_DISTANCE, 0);
    random_traffic(60);
    settle();

    write_reg(CFG_MISS_LIMIT, 2);
    write_reg(CFG_GATE_DISTANCE, 800);
    random_traffic(130);
    settle();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
